@@ src/ccsc_pkg.sv @@
// shared types and constants of the crc codeword stream checker
// no dependencies
`default_nettype none

package ccsc_pkg;

   localparam int MAX_GEN_BITS_DEF = 9;
   localparam int COUNT_BITS_DEF   = 24;

   localparam int DW_MAX   = 8;
   localparam int TOTAL_W  = 24;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 9;

   localparam logic [CSR_IDX_W-1:0] CSR_GENERATOR      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GENERATOR_LEN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DATAWORD_EIGHT = 2'd2;

   localparam logic [8:0] GENERATOR_RESET     = 9'd11;
   localparam logic [3:0] GENERATOR_LEN_RESET = 4'd4;
   localparam logic       DATAWORD_EIGHT_RESET = 1'b0;

   localparam logic RESULT_DATA    = 1'b0;
   localparam logic RESULT_SUMMARY = 1'b1;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       first_byte;
      logic       final_byte;
   } ccsc_req_type;

   typedef struct packed {
      logic               result_kind;
      logic [7:0]         data_byte;
      logic [TOTAL_W-1:0] codeword_total;
      logic [TOTAL_W-1:0] error_total;
      logic               last_result;
   } ccsc_rsp_type;

   typedef struct packed {
      logic [8:0] generator;
      logic [3:0] generator_length;
      logic       dataword_eight;
   } ccsc_cfg_type;

   typedef struct packed {
      logic clear_file;
      logic step_bit;
      logic bit_value;
      logic emit_allowed;
   } ccsc_step_ctrl_type;

   typedef struct packed {
      logic       byte_emit;
      logic [7:0] data_byte;
   } ccsc_step_stat_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_PUSH_DATA,
      ST_PUSH_SUM
   } ccsc_state_type;

endpackage

`default_nettype wire

@@ src/crc_codeword_stream_checker_core.sv @@
// crc codeword stream checker: top level with sequencer and configuration registers
// depends on ccsc_pkg, ccsc_step_unit, ccsc_rsp_fifo
//
// usage
// req channel: one file byte per transaction; first_byte marks the padding
// count byte that opens a file, final_byte marks the last byte and asks for a
// summary. rsp channel: recovered data bytes (at most one per request byte)
// and end of file summaries with saturating codeword and error counts.
// csr channel: always ready, index 0 generator, 1 generator length,
// 2 dataword size; write only while no request is in flight.
// timing: a padding count byte needs only the accept state, plus the summary
// push state when it also closes the file; any other byte is accepted, then
// stepped through the bit-serial step unit, one bit per cycle, then each result
// it produces is pushed. each result is registered in the queue before it is on rsp.
// a two-entry result queue sits in front of rsp: a stalled receiver only holds
// up the sequencer once the queue has no room for the next result.
// reset: synchronous; clears the file state and counters, loads the default
// configuration (generator 1011, length 4, 4-bit datawords), empties the queue.
`default_nettype none

module crc_codeword_stream_checker_core #(
   parameter int MAX_GEN_BITS = ccsc_pkg::MAX_GEN_BITS_DEF,
   parameter int COUNT_BITS   = ccsc_pkg::COUNT_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  ccsc_pkg::ccsc_req_type              req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output ccsc_pkg::ccsc_rsp_type              rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ccsc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ccsc_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import ccsc_pkg::*;

   ccsc_state_type     state_ff, state_in;
   ccsc_cfg_type       cfg_ff;
   logic [7:0]         byte_ff;
   logic               final_ff;
   logic [2:0]         bit_idx_ff;
   logic               data_pend_ff;
   logic [7:0]         data_byte_ff;

   ccsc_step_ctrl_type ctrl;
   ccsc_step_stat_type stat;
   logic [COUNT_BITS-1:0] cw_count, err_count;
   logic [TOTAL_W-1:0]    cw_total, err_total;

   logic         req_accept;
   logic         push_valid, push_ready;
   ccsc_rsp_type push_entry;

   assign csr_ready  = 1'b1;
   assign req_accept = req_valid && req_ready;

   generate
      if (COUNT_BITS >= TOTAL_W) begin : g_total_trunc
         assign cw_total  = cw_count[TOTAL_W-1:0];
         assign err_total = err_count[TOTAL_W-1:0];
      end else begin : g_total_ext
         assign cw_total  = {{(TOTAL_W-COUNT_BITS){1'b0}}, cw_count};
         assign err_total = {{(TOTAL_W-COUNT_BITS){1'b0}}, err_count};
      end
   endgenerate

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (!req_payload.first_byte) begin
                  state_in = ST_SHIFT;
               end else if (req_payload.final_byte) begin
                  state_in = ST_PUSH_SUM;
               end
            end
         end
         ST_SHIFT: begin
            if (bit_idx_ff == 3'd0) begin
               if (data_pend_ff || stat.byte_emit) begin
                  state_in = ST_PUSH_DATA;
               end else if (final_ff) begin
                  state_in = ST_PUSH_SUM;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_PUSH_DATA: begin
            if (push_ready) begin
               state_in = final_ff ? ST_PUSH_SUM : ST_IDLE;
            end
         end
         ST_PUSH_SUM: begin
            if (push_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready         = 1'b0;
      push_valid        = 1'b0;
      ctrl.clear_file   = 1'b0;
      ctrl.step_bit     = 1'b0;
      ctrl.bit_value    = byte_ff[bit_idx_ff];
      ctrl.emit_allowed = !data_pend_ff;
      push_entry.result_kind    = RESULT_DATA;
      push_entry.data_byte      = data_byte_ff;
      push_entry.codeword_total = '0;
      push_entry.error_total    = '0;
      push_entry.last_result    = !final_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready       = 1'b1;
            ctrl.clear_file = req_valid && req_payload.first_byte;
         end
         ST_SHIFT: begin
            ctrl.step_bit = 1'b1;
         end
         ST_PUSH_DATA: begin
            push_valid = 1'b1;
         end
         ST_PUSH_SUM: begin
            push_valid                = 1'b1;
            push_entry.result_kind    = RESULT_SUMMARY;
            push_entry.data_byte      = '0;
            push_entry.codeword_total = cw_total;
            push_entry.error_total    = err_total;
            push_entry.last_result    = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         data_pend_ff <= 1'b0;
         final_ff     <= 1'b0;
         bit_idx_ff   <= '0;
         cfg_ff.generator        <= GENERATOR_RESET;
         cfg_ff.generator_length <= GENERATOR_LEN_RESET;
         cfg_ff.dataword_eight   <= DATAWORD_EIGHT_RESET;
      end else begin
         state_ff <= state_in;
         if (req_accept) begin
            final_ff     <= req_payload.final_byte;
            bit_idx_ff   <= 3'd7;
            data_pend_ff <= 1'b0;
         end else if (state_ff == ST_SHIFT) begin
            bit_idx_ff <= bit_idx_ff - 3'd1;
            if (stat.byte_emit) begin
               data_pend_ff <= 1'b1;
            end
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_GENERATOR:      cfg_ff.generator        <= csr_wdata[8:0];
               CSR_GENERATOR_LEN:  cfg_ff.generator_length <= csr_wdata[3:0];
               CSR_DATAWORD_EIGHT: cfg_ff.dataword_eight   <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         byte_ff <= req_payload.in_byte;
      end
      if (state_ff == ST_SHIFT && stat.byte_emit) begin
         data_byte_ff <= stat.data_byte;
      end
   end

   ccsc_step_unit #(
      .MAX_GEN_BITS (MAX_GEN_BITS),
      .COUNT_BITS   (COUNT_BITS)
   ) u_step (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .ctrl      (ctrl),
      .skip_load (req_payload.in_byte),
      .stat      (stat),
      .cw_count  (cw_count),
      .err_count (err_count)
   );

   ccsc_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_entry),
      .pop_valid  (rsp_valid),
      .pop_ready  (rsp_ready),
      .pop_data   (rsp_payload)
   );

endmodule

`default_nettype wire

@@ src/ccsc_step_unit.sv @@
// bit-serial step unit: padding skip, codeword gathering, mod-2 check, data repacking
// depends on ccsc_pkg
`default_nettype none

module ccsc_step_unit #(
   parameter int MAX_GEN_BITS = ccsc_pkg::MAX_GEN_BITS_DEF,
   parameter int COUNT_BITS   = ccsc_pkg::COUNT_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ccsc_pkg::ccsc_cfg_type       cfg,
   input  ccsc_pkg::ccsc_step_ctrl_type ctrl,
   input  logic [7:0]                   skip_load,
   output ccsc_pkg::ccsc_step_stat_type stat,
   output logic [COUNT_BITS-1:0]        cw_count,
   output logic [COUNT_BITS-1:0]        err_count
);
   import ccsc_pkg::*;

   localparam int CW_BITS = MAX_GEN_BITS + DW_MAX - 1;
   localparam int CWL_W   = $clog2(CW_BITS + 1);
   localparam int IDX_W   = $clog2(CW_BITS);
   localparam int GLEN_W  = $clog2(MAX_GEN_BITS + 1);

   logic [7:0]            skip_ff, skip_in;
   logic [CW_BITS-1:0]    cw_shift_ff, cw_shift_in;
   logic [4:0]            cw_fill_ff, cw_fill_in;
   logic [15:0]           data_shift_ff, data_shift_in;
   logic [4:0]            data_fill_ff, data_fill_in;
   logic [COUNT_BITS-1:0] cw_count_ff, cw_count_in;
   logic [COUNT_BITS-1:0] err_count_ff, err_count_in;

   logic [GLEN_W-1:0]  glen;
   logic [3:0]         dw;
   logic [CWL_W-1:0]   cwlen;
   logic [CW_BITS-1:0] cw_mask, gen_mask, gen_m, shifted, rem, dtmp;
   logic [4:0]         fill_nx, fill_add, fill_emit;
   logic               cw_done, cw_error;
   logic [7:0]         dbits, byte_out;
   logic [15:0]        ds_add, emit_mask;

   // configuration decode
   always_comb begin
      if (int'(cfg.generator_length) < 2) begin
         glen = GLEN_W'(2);
      end else if (int'(cfg.generator_length) > MAX_GEN_BITS) begin
         glen = GLEN_W'(MAX_GEN_BITS);
      end else begin
         glen = GLEN_W'(cfg.generator_length);
      end
      dw    = cfg.dataword_eight ? 4'd8 : 4'd4;
      cwlen = CWL_W'(dw) + CWL_W'(glen) - CWL_W'(1);
      for (int i = 0; i < CW_BITS; i++) begin
         cw_mask[i]  = (i < int'(cwlen));
         gen_mask[i] = (i < int'(glen));
      end
      gen_m = CW_BITS'(cfg.generator) & gen_mask;
   end

   // codeword gathering and mod-2 division
   always_comb begin
      logic [IDX_W-1:0] pos;
      pos      = '0;
      shifted  = {cw_shift_ff[CW_BITS-2:0], ctrl.bit_value} & cw_mask;
      fill_nx  = cw_fill_ff + 5'd1;
      cw_done  = (int'(fill_nx) >= int'(cwlen));
      rem      = shifted;
      for (int i = 0; i < DW_MAX; i++) begin
         if (i < int'(dw)) begin
            pos = IDX_W'(int'(cwlen) - 1 - i);
            if (rem[pos]) begin
               rem = rem ^ (gen_m << (int'(dw) - 1 - i));
            end
         end
      end
      cw_error = |rem;
   end

   // dataword repacking
   always_comb begin
      dtmp      = shifted >> (int'(glen) - 1);
      dbits     = 8'(dtmp) & (cfg.dataword_eight ? 8'hFF : 8'h0F);
      ds_add    = cfg.dataword_eight ? {data_shift_ff[7:0], dbits}
                                     : {data_shift_ff[11:0], dbits[3:0]};
      fill_add  = data_fill_ff + 5'(dw);
      fill_emit = fill_add - 5'd8;
      byte_out  = 8'(ds_add >> fill_emit);
      for (int i = 0; i < 16; i++) begin
         emit_mask[i] = (i < int'(fill_emit));
      end
   end

   always_comb begin
      skip_in        = skip_ff;
      cw_shift_in    = cw_shift_ff;
      cw_fill_in     = cw_fill_ff;
      data_shift_in  = data_shift_ff;
      data_fill_in   = data_fill_ff;
      cw_count_in    = cw_count_ff;
      err_count_in   = err_count_ff;
      stat.byte_emit = 1'b0;
      stat.data_byte = byte_out;
      if (ctrl.clear_file) begin
         skip_in       = skip_load;
         cw_shift_in   = '0;
         cw_fill_in    = '0;
         data_shift_in = '0;
         data_fill_in  = '0;
         cw_count_in   = '0;
         err_count_in  = '0;
      end else if (ctrl.step_bit) begin
         if (skip_ff != 8'd0) begin
            skip_in = skip_ff - 8'd1;
         end else if (!cw_done) begin
            cw_shift_in = shifted;
            cw_fill_in  = fill_nx;
         end else begin
            cw_shift_in = '0;
            cw_fill_in  = '0;
            if (cw_count_ff != '1) begin
               cw_count_in = cw_count_ff + COUNT_BITS'(1);
            end
            if (cw_error && err_count_ff != '1) begin
               err_count_in = err_count_ff + COUNT_BITS'(1);
            end
            if (fill_add >= 5'd8 && ctrl.emit_allowed) begin
               stat.byte_emit = 1'b1;
               data_fill_in   = fill_emit;
               data_shift_in  = ds_add & emit_mask;
            end else if (fill_add > 5'd12) begin
               data_fill_in  = 5'd12;
               data_shift_in = ds_add & 16'h0FFF;
            end else begin
               data_fill_in  = fill_add;
               data_shift_in = ds_add;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff       <= '0;
         cw_shift_ff   <= '0;
         cw_fill_ff    <= '0;
         data_shift_ff <= '0;
         data_fill_ff  <= '0;
         cw_count_ff   <= '0;
         err_count_ff  <= '0;
      end else begin
         skip_ff       <= skip_in;
         cw_shift_ff   <= cw_shift_in;
         cw_fill_ff    <= cw_fill_in;
         data_shift_ff <= data_shift_in;
         data_fill_ff  <= data_fill_in;
         cw_count_ff   <= cw_count_in;
         err_count_ff  <= err_count_in;
      end
   end

   assign cw_count  = cw_count_ff;
   assign err_count = err_count_ff;

endmodule

`default_nettype wire

@@ src/ccsc_rsp_fifo.sv @@
// two-entry result queue between the sequencer and the rsp channel
// depends on ccsc_pkg
`default_nettype none

module ccsc_rsp_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  ccsc_pkg::ccsc_rsp_type push_data,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output ccsc_pkg::ccsc_rsp_type pop_data
);
   import ccsc_pkg::*;

   localparam logic [1:0] DEPTH = 2'd2;

   ccsc_rsp_type entry_ff [2];
   logic [1:0]   count_ff, count_in;
   logic         wr_ptr_ff, rd_ptr_ff;
   logic         push, pop;

   assign push_ready = (count_ff != DEPTH);
   assign pop_valid  = (count_ff != 2'd0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ src/ccsc_checker.sv @@
// port-level checks of the crc codeword stream checker, bound to the top level
// depends on ccsc_pkg and crc_codeword_stream_checker_core
`default_nettype none

module ccsc_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input ccsc_pkg::ccsc_req_type req_payload,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input ccsc_pkg::ccsc_rsp_type rsp_payload
);
   import ccsc_pkg::*;

   // a stalled result transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp transaction changed while stalled");

   // a data byte keeps the sequencer busy for its bit steps
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_payload.first_byte |=> !req_ready)
      else $error("req accepted during bit steps");

   // summaries always close the results of their byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.result_kind == RESULT_SUMMARY |-> rsp_payload.last_result)
      else $error("summary without last_result");

   // data results carry no counts
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.result_kind == RESULT_DATA
      |-> rsp_payload.codeword_total == '0 && rsp_payload.error_total == '0)
      else $error("data result with nonzero totals");

endmodule

bind crc_codeword_stream_checker_core ccsc_checker u_ccsc_checker (.*);

`default_nettype wire
